>>> sv/tasdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasdg_pkg: shared types and constants for the step/dir generator
// Request and result payloads, per-axis control/view bundles, command and
// register codes, fixed delays.
// ----------------------------------------------------------------------------
package tasdg_pkg;

	localparam int NUM_AXES_DEF = 3;

	localparam int CMD_W     = 2;
	localparam int AXIS_W    = 2;
	localparam int POS_W     = 32;
	localparam int DELAY_W   = 16;
	localparam int COUNT_W   = 17;
	localparam int TICK_W    = 10;
	localparam int MAXPOS_W  = 31;
	localparam int FLAG_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 31;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_HOME = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICK_US    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_INVERT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POS_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POS_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POS_Z  = 3'd4;

	localparam logic [TICK_W-1:0]   TICK_US_RST  = 10'd10;
	localparam logic [MAXPOS_W-1:0] MAX_POS_RST  = 31'h7FFF_FFFF;
	localparam logic [DELAY_W-1:0]  MIN_DELAY    = 16'd100;
	localparam logic [DELAY_W-1:0]  HOME_DLY_XY  = 16'd500;
	localparam logic [DELAY_W-1:0]  HOME_DLY_Z   = 16'd200;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic [AXIS_W-1:0]       axis;
		logic signed [POS_W-1:0] target_pos;
		logic [DELAY_W-1:0]      step_delay_us;
		logic [FLAG_W-1:0]       home_levels;
		logic                    stop_active;
	} cmd_item_t;

	typedef struct packed {
		logic [FLAG_W-1:0]       step_lines;
		logic [FLAG_W-1:0]       dir_lines;
		logic [FLAG_W-1:0]       busy_flags;
		logic                    any_busy;
		logic                    all_at_zero;
		logic [FLAG_W-1:0]       home_flags;
		logic signed [POS_W-1:0] position_x;
		logic signed [POS_W-1:0] position_y;
		logic signed [POS_W-1:0] position_z;
	} result_t;

	typedef struct packed {
		logic                    tick;
		logic                    set_tgt;
		logic                    start_home;
		logic                    home_pressed;
		logic                    inv;
		logic [TICK_W-1:0]       tick_us;
		logic [MAXPOS_W-1:0]     max_pos;
		logic signed [POS_W-1:0] target_pos;
		logic [DELAY_W-1:0]      step_delay;
		logic [DELAY_W-1:0]      home_delay;
	} axis_ctl_t;

	typedef struct packed {
		logic step;
		logic dir;
		logic busy;
		logic home;
	} axis_view_t;

endpackage

>>> sv/tasdg_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasdg_axis: one axis of the step/dir generator
// Holds the axis state and computes its next state for one request.
// ----------------------------------------------------------------------------
module tasdg_axis (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  tasdg_pkg::axis_ctl_t               ctl,
	output tasdg_pkg::axis_view_t              view,
	output logic signed [tasdg_pkg::POS_W-1:0] pos_nx
);

	logic signed [tasdg_pkg::POS_W-1:0] pos_q, tgt_q, tgt_d, clamped;
	logic [tasdg_pkg::DELAY_W-1:0]      dly_q, dly_d;
	logic [tasdg_pkg::COUNT_W-1:0]      cnt_q, cnt_d, cnt_sat;
	logic [tasdg_pkg::COUNT_W:0]        cnt_sum;
	logic homing_q, homing_d, step_q, step_d, dir_q, dir_d, busy_q, busy_d;
	logic home_q, home_d, reach, clamp_hi;

	assign cnt_sum = {1'b0, cnt_q} + (tasdg_pkg::COUNT_W+1)'(ctl.tick_us);
	assign cnt_sat = cnt_sum[tasdg_pkg::COUNT_W] ? '1 : cnt_sum[tasdg_pkg::COUNT_W-1:0];
	assign reach   = cnt_sat >= tasdg_pkg::COUNT_W'(dly_q);

	// negative targets never exceed the (non-negative) maximum
	assign clamp_hi = !ctl.target_pos[tasdg_pkg::POS_W-1]
		&& (ctl.target_pos[tasdg_pkg::POS_W-2:0] > ctl.max_pos);
	assign clamped  = clamp_hi ? signed'({1'b0, ctl.max_pos}) : ctl.target_pos;

	always_comb begin
		pos_nx   = pos_q;
		tgt_d    = tgt_q;
		dly_d    = dly_q;
		cnt_d    = cnt_q;
		homing_d = homing_q;
		step_d   = step_q;
		dir_d    = dir_q;
		busy_d   = busy_q;
		home_d   = ctl.tick ? ctl.home_pressed : home_q;
		if (ctl.tick) begin
			if (!reach) begin
				cnt_d = cnt_sat;
			end else begin
				cnt_d = '0;
				if (homing_q) begin
					if (home_d) begin
						pos_nx   = '0;
						tgt_d    = '0;
						homing_d = 1'b0;
						busy_d   = 1'b0;
					end else begin
						busy_d = 1'b1;
						dir_d  = !ctl.inv;
						step_d = !step_q;
					end
				end else if (tgt_q != pos_q) begin
					busy_d = 1'b1;
					step_d = !step_q;
					if (tgt_q < pos_q) begin
						pos_nx = pos_q - 32'sd1;
						dir_d  = !ctl.inv;
					end else begin
						pos_nx = pos_q + 32'sd1;
						dir_d  = ctl.inv;
					end
				end else begin
					busy_d = 1'b0;
				end
			end
		end else if (ctl.set_tgt) begin
			tgt_d = clamped;
			dly_d = (ctl.step_delay < tasdg_pkg::MIN_DELAY) ? tasdg_pkg::MIN_DELAY
				: ctl.step_delay;
			if (clamped != pos_q) busy_d = 1'b1;
		end else if (ctl.start_home) begin
			dly_d    = ctl.home_delay;
			homing_d = 1'b1;
			if (!home_q) busy_d = 1'b1;
		end
	end

	assign view = '{step: step_d, dir: dir_d, busy: busy_d, home: home_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			tgt_q    <= '0;
			dly_q    <= '0;
			cnt_q    <= '0;
			homing_q <= 1'b0;
			step_q   <= 1'b0;
			dir_q    <= 1'b0;
			busy_q   <= 1'b0;
			home_q   <= 1'b0;
		end else if (en) begin
			pos_q    <= pos_nx;
			tgt_q    <= tgt_d;
			dly_q    <= dly_d;
			cnt_q    <= cnt_d;
			homing_q <= homing_d;
			step_q   <= step_d;
			dir_q    <= dir_d;
			busy_q   <= busy_d;
			home_q   <= home_d;
		end
	end

endmodule

>>> sv/three_axis_step_dir_generator.sv
// A request accepted into the request register has its result registered in
// the result register. Throughput: one request per cycle unless an unread
// result stalls; axes update in parallel (counter add/compare, position step).
// Reset (arst_n low): all axis state zero, tick_us 10, dir_invert 0,
// max_pos_* 0x7FFFFFFF, both stages empty.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_step_dir_generator: stepper step/dir generator with homing
// Request register -> per-axis next-state logic -> result register.
// Ticks advance delay counters and step axes toward their target or home
// switch; set/home commands load per-axis target, delay and mode.
// ----------------------------------------------------------------------------
module three_axis_step_dir_generator #(
	parameter int NUM_AXES = tasdg_pkg::NUM_AXES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  tasdg_pkg::cmd_item_t                 in_data,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output tasdg_pkg::result_t                   out_data,
	// configuration writes
	input  logic                                 cfg_wr_en,
	input  logic [tasdg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tasdg_pkg::CFG_DAT_W-1:0]      cfg_data
);

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [tasdg_pkg::TICK_W-1:0]   tick_us_q;
	logic [tasdg_pkg::FLAG_W-1:0]   dir_inv_q;
	logic [tasdg_pkg::MAXPOS_W-1:0] max_x_q, max_y_q, max_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_us_q <= tasdg_pkg::TICK_US_RST;
			dir_inv_q <= '0;
			max_x_q   <= tasdg_pkg::MAX_POS_RST;
			max_y_q   <= tasdg_pkg::MAX_POS_RST;
			max_z_q   <= tasdg_pkg::MAX_POS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tasdg_pkg::REG_TICK_US:    tick_us_q <= cfg_data[tasdg_pkg::TICK_W-1:0];
				tasdg_pkg::REG_DIR_INVERT: dir_inv_q <= cfg_data[tasdg_pkg::FLAG_W-1:0];
				tasdg_pkg::REG_MAX_POS_X:  max_x_q   <= cfg_data;
				tasdg_pkg::REG_MAX_POS_Y:  max_y_q   <= cfg_data;
				tasdg_pkg::REG_MAX_POS_Z:  max_z_q   <= cfg_data;
				default: ; // writes past the register list are dropped
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Request register. The request is held here until the result register
	// can take its result; fire is the cycle in which state is updated.
	// ---------------------------------------------------------------------
	tasdg_pkg::cmd_item_t item_s1;
	logic                 vld_s1;
	tasdg_pkg::result_t   res_s2, res_d;
	logic                 vld_s2;
	logic                 fire;

	assign fire     = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Tick with stop set, and the unused command code, touch nothing: no
	// axis control line is raised and the result shows the held state.
	logic tick_go;
	assign tick_go = (item_s1.cmd == tasdg_pkg::CMD_TICK) && !item_s1.stop_active;

	// ---------------------------------------------------------------------
	// Axis units
	// ---------------------------------------------------------------------
	tasdg_pkg::axis_ctl_t               ctl  [NUM_AXES];
	tasdg_pkg::axis_view_t              view [NUM_AXES];
	logic signed [tasdg_pkg::POS_W-1:0] pos_nx [NUM_AXES];
	logic [NUM_AXES-1:0]                step_v, dir_v, busy_v, home_v, zero_v;

	for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
		if (i < 3) begin : g_real
			// only axes 0..2 can be addressed and have a home switch
			assign ctl[i].set_tgt      = (item_s1.cmd == tasdg_pkg::CMD_SET)
				&& (item_s1.axis == tasdg_pkg::AXIS_W'(i));
			assign ctl[i].start_home   = (item_s1.cmd == tasdg_pkg::CMD_HOME)
				&& (item_s1.axis == tasdg_pkg::AXIS_W'(i));
			assign ctl[i].home_pressed = !item_s1.home_levels[i];
			assign ctl[i].inv          = dir_inv_q[i];
			assign ctl[i].max_pos      = (i == 0) ? max_x_q : (i == 1) ? max_y_q : max_z_q;
			assign ctl[i].home_delay   = (i < 2) ? tasdg_pkg::HOME_DLY_XY
				: tasdg_pkg::HOME_DLY_Z;
		end else begin : g_extra
			assign ctl[i].set_tgt      = 1'b0;
			assign ctl[i].start_home   = 1'b0;
			assign ctl[i].home_pressed = 1'b0;
			assign ctl[i].inv          = 1'b0;
			assign ctl[i].max_pos      = tasdg_pkg::MAX_POS_RST;
			assign ctl[i].home_delay   = tasdg_pkg::HOME_DLY_XY;
		end
		assign ctl[i].tick       = tick_go;
		assign ctl[i].tick_us    = tick_us_q;
		assign ctl[i].target_pos = item_s1.target_pos;
		assign ctl[i].step_delay = item_s1.step_delay_us;

		tasdg_axis u_axis (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (fire),
			.ctl    (ctl[i]),
			.view   (view[i]),
			.pos_nx (pos_nx[i])
		);

		assign step_v[i] = view[i].step;
		assign dir_v[i]  = view[i].dir;
		assign busy_v[i] = view[i].busy;
		assign home_v[i] = view[i].home;
		assign zero_v[i] = (pos_nx[i] == '0);
	end

	// ---------------------------------------------------------------------
	// Result assembly: flag fields carry axes 0..2, absent axes read zero.
	// ---------------------------------------------------------------------
	logic [tasdg_pkg::FLAG_W-1:0]       step3, dir3, busy3, home3;
	logic signed [tasdg_pkg::POS_W-1:0] pos3 [tasdg_pkg::FLAG_W];

	for (genvar j = 0; j < tasdg_pkg::FLAG_W; j++) begin : g_pad
		if (j < NUM_AXES) begin : g_on
			assign step3[j] = step_v[j];
			assign dir3[j]  = dir_v[j];
			assign busy3[j] = busy_v[j];
			assign home3[j] = home_v[j];
			assign pos3[j]  = pos_nx[j];
		end else begin : g_off
			assign step3[j] = 1'b0;
			assign dir3[j]  = 1'b0;
			assign busy3[j] = 1'b0;
			assign home3[j] = 1'b0;
			assign pos3[j]  = '0;
		end
	end

	always_comb begin
		res_d             = '0;
		res_d.step_lines  = step3;
		res_d.dir_lines   = dir3;
		res_d.busy_flags  = busy3;
		res_d.any_busy    = |busy_v;
		res_d.all_at_zero = &zero_v;
		res_d.home_flags  = home3;
		res_d.position_x  = pos3[0];
		res_d.position_y  = pos3[1];
		res_d.position_z  = pos3[2];
	end

	// ---------------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (fire) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = res_s2;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	// a processed request always lands in the result register
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("processed request produced no result");

	// a request that cannot move on stays put in the request register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !fire |=> vld_s1 && $stable(item_s1))
		else $error("held request lost or changed");

	// all_at_zero agrees with the reported positions
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.all_at_zero |->
			out_data.position_x == '0 && out_data.position_y == '0
			&& out_data.position_z == '0)
		else $error("all_at_zero set with a nonzero position");

	// any_busy tracks the per-axis busy flags
	a_any_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.any_busy == (out_data.busy_flags != '0))
		else $error("any_busy disagrees with busy_flags");

endmodule
